/* rtl/core/tdfa_pkg.sv */
// tdfa_pkg: shared widths, constants and types of the ternary dot product core
// used by tdfa_front, tdfa_fifo, tdfa_back and ternary_dot_fc_accumulate_core
`timescale 1ns / 1ps
`default_nettype none

package tdfa_pkg;

	localparam int LANES          = 8;
	localparam int ACT_W          = 16;
	localparam int MASK_W         = LANES;
	localparam int BIAS_W         = 16;
	localparam int OUT_W          = 16;
	localparam int ALPHA_W        = 16;
	localparam int ALPHA_FRAC     = 12;
	// one extra bit so that eight subtracted -32768 lanes still fit
	localparam int DELTA_W        = ACT_W + $clog2(LANES) + 1;
	localparam int IN_DATA_W      = LANES * ACT_W + 2 * MASK_W + BIAS_W;
	localparam int PLUS_LSB       = LANES * ACT_W;
	localparam int MINUS_LSB      = PLUS_LSB + MASK_W;
	localparam int BIAS_LSB       = MINUS_LSB + MASK_W;
	localparam int ACC_WIDTH_DEF  = 32;
	localparam int FIFO_DEPTH_DEF = 4;

	localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'h1000;
	localparam int OUT_MAX     = 32767;
	localparam int OUT_MIN_MAG = 32768;

	typedef struct packed {
		logic signed [DELTA_W-1:0] delta;
		logic signed [BIAS_W-1:0]  bias;
		logic                      last;
	} tdfa_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic push;
		logic pop;
	} tdfa_fifo_status_t;

endpackage

`default_nettype wire

/* rtl/core/tdfa_front.sv */
// tdfa_front: input stage, resolves the ternary lane masks and sums the lanes
// depends on tdfa_pkg
`timescale 1ns / 1ps
`default_nettype none

module tdfa_front (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [tdfa_pkg::IN_DATA_W-1:0]    in_data,
	input  wire logic                              in_last,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output tdfa_pkg::tdfa_entry_t                  out_entry
);

	logic                                  vld_s1;
	tdfa_pkg::tdfa_entry_t                 ent_s1;
	logic signed [tdfa_pkg::DELTA_W-1:0]   delta;
	logic [tdfa_pkg::MASK_W-1:0]           plus_bits;
	logic [tdfa_pkg::MASK_W-1:0]           minus_bits;

	assign plus_bits  = in_data[tdfa_pkg::PLUS_LSB +: tdfa_pkg::MASK_W];
	assign minus_bits = in_data[tdfa_pkg::MINUS_LSB +: tdfa_pkg::MASK_W];

	// plus bit wins over minus bit
	always_comb begin
		logic signed [tdfa_pkg::DELTA_W-1:0] lane;
		delta = '0;
		for (int i = 0; i < tdfa_pkg::LANES; i++) begin
			lane = tdfa_pkg::DELTA_W'($signed(in_data[i*tdfa_pkg::ACT_W +: tdfa_pkg::ACT_W]));
			if (plus_bits[i]) begin
				delta = delta + lane;
			end else if (minus_bits[i]) begin
				delta = delta - lane;
			end
		end
	end

	assign in_ready = !vld_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			ent_s1.delta <= delta;
			ent_s1.bias  <= $signed(in_data[tdfa_pkg::BIAS_LSB +: tdfa_pkg::BIAS_W]);
			ent_s1.last  <= in_last;
		end
	end

	assign out_valid = vld_s1;
	assign out_entry = ent_s1;

endmodule

`default_nettype wire

/* rtl/core/tdfa_fifo.sv */
// tdfa_fifo: short queue of lane sums between the front and back stages
// depends on tdfa_pkg
`timescale 1ns / 1ps
`default_nettype none

module tdfa_fifo #(
	parameter int DEPTH = tdfa_pkg::FIFO_DEPTH_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    push_valid,
	output logic                         push_ready,
	input  wire tdfa_pkg::tdfa_entry_t   push_entry,
	output logic                         pop_valid,
	input  wire logic                    pop_ready,
	output tdfa_pkg::tdfa_entry_t        pop_entry,
	output tdfa_pkg::tdfa_fifo_status_t  status
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	tdfa_pkg::tdfa_entry_t  mem_q [DEPTH];
	logic [PTR_W-1:0]       wr_ptr_q;
	logic [PTR_W-1:0]       rd_ptr_q;
	logic [CNT_W-1:0]       count_q;
	logic                   full;
	logic                   empty;
	logic                   push;
	logic                   pop;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign empty      = (count_q == '0);
	assign push_ready = !full;
	assign pop_valid  = !empty;
	assign push       = push_valid && !full;
	assign pop        = pop_ready && !empty;
	assign pop_entry  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	assign status = '{full: full, empty: empty, push: push, pop: pop};

endmodule

`default_nettype wire

/* rtl/core/tdfa_back.sv */
// tdfa_back: accumulator, alpha scaling, bias add, rounding and saturation
// depends on tdfa_pkg
`timescale 1ns / 1ps
`default_nettype none

module tdfa_back #(
	parameter int ACC_WIDTH = tdfa_pkg::ACC_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [tdfa_pkg::ALPHA_W-1:0]  alpha_scale,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire tdfa_pkg::tdfa_entry_t         in_entry,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [tdfa_pkg::OUT_W-1:0]         out_data
);

	localparam int PROD_W = ACC_WIDTH + tdfa_pkg::ALPHA_W + 1;
	localparam int SUM_W  = PROD_W + 1;
	localparam int Q_W    = SUM_W + 1 - tdfa_pkg::ALPHA_FRAC;
	localparam int RND    = 1 << (tdfa_pkg::ALPHA_FRAC - 1);

	logic signed [ACC_WIDTH-1:0]        acc_q;
	logic signed [ACC_WIDTH-1:0]        acc_next;
	logic                               vld_s1;
	logic signed [ACC_WIDTH-1:0]        acc_s1;
	logic signed [tdfa_pkg::BIAS_W-1:0] bias_s1;
	logic                               vld_s2;
	logic signed [PROD_W-1:0]           prod_s2;
	logic signed [tdfa_pkg::BIAS_W-1:0] bias_s2;
	logic                               vld_s3;
	logic signed [SUM_W-1:0]            sum_s3;
	logic                               out_vld_q;
	logic [tdfa_pkg::OUT_W-1:0]         out_q;
	logic                               rdy_s1;
	logic                               rdy_s2;
	logic                               rdy_s3;
	logic                               rdy_out;
	logic                               take;
	logic signed [SUM_W-1:0]            bias_ext;
	logic                               neg;
	logic [SUM_W:0]                     rnd;
	logic [Q_W-1:0]                     q;
	logic [tdfa_pkg::OUT_W-1:0]         sat;

	assign rdy_out  = !out_vld_q || out_ready;
	assign rdy_s3   = !vld_s3 || rdy_out;
	assign rdy_s2   = !vld_s2 || rdy_s3;
	assign rdy_s1   = !vld_s1 || rdy_s2;
	assign in_ready = !in_entry.last || rdy_s1;
	assign take     = in_valid && in_ready;
	assign acc_next = acc_q + ACC_WIDTH'(in_entry.delta);

	assign bias_ext = {{(SUM_W - tdfa_pkg::BIAS_W - tdfa_pkg::ALPHA_FRAC){bias_s2[tdfa_pkg::BIAS_W-1]}},
		bias_s2, {tdfa_pkg::ALPHA_FRAC{1'b0}}};

	// half away from zero: magnitude of a negative sum is ~sum + 1
	always_comb begin
		neg = sum_s3[SUM_W-1];
		if (neg) begin
			rnd = {1'b0, ~sum_s3} + (SUM_W + 1)'(RND + 1);
		end else begin
			rnd = {1'b0, sum_s3} + (SUM_W + 1)'(RND);
		end
		q = rnd[SUM_W:tdfa_pkg::ALPHA_FRAC];
		if (neg) begin
			if (q > Q_W'(tdfa_pkg::OUT_MIN_MAG)) begin
				sat = tdfa_pkg::OUT_W'(tdfa_pkg::OUT_MIN_MAG);
			end else begin
				sat = tdfa_pkg::OUT_W'(~q + 1'b1);
			end
		end else begin
			if (q > Q_W'(tdfa_pkg::OUT_MAX)) begin
				sat = tdfa_pkg::OUT_W'(tdfa_pkg::OUT_MAX);
			end else begin
				sat = q[tdfa_pkg::OUT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (take) begin
				acc_q <= in_entry.last ? '0 : acc_next;
			end
			if (rdy_s1) begin
				vld_s1 <= take && in_entry.last;
			end
			if (rdy_s2) begin
				vld_s2 <= vld_s1;
			end
			if (rdy_s3) begin
				vld_s3 <= vld_s2;
			end
			if (rdy_out) begin
				out_vld_q <= vld_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && take && in_entry.last) begin
			acc_s1  <= acc_next;
			bias_s1 <= in_entry.bias;
		end
		if (rdy_s2 && vld_s1) begin
			prod_s2 <= PROD_W'(acc_s1) * $signed({1'b0, alpha_scale});
			bias_s2 <= bias_s1;
		end
		if (rdy_s3 && vld_s2) begin
			sum_s3 <= SUM_W'(prod_s2) + bias_ext;
		end
		if (rdy_out && vld_s3) begin
			out_q <= sat;
		end
	end

	assign out_valid = out_vld_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

/* rtl/core/ternary_dot_fc_accumulate_core.sv */
// ternary_dot_fc_accumulate_core: top level of the ternary weight dot product neuron
// depends on tdfa_pkg, tdfa_front, tdfa_fifo, tdfa_back
//
//  channel   direction  handshake               payload
//  s_axis    in         tvalid/tready           tdata (lanes, masks, bias), tlast
//  m_axis    out        tvalid/tready           tdata (neuron_out)
//  cfg       in         cfg_valid/cfg_ready     cfg_data (alpha_scale)
//
// one request per cycle while the output is not stalled: lane sum in the front register, accumulate on fifo pop
// after its last request is taken, a result passes the queue, accumulate, multiply, bias add
// and round/saturate registers, the multiplier stage sets the clock
// reset clears the accumulator, queue and valids; alpha resets to 1.0
// a stalled output backs up the result pipe, then the queue, then s_axis_tready
`timescale 1ns / 1ps
`default_nettype none

module ternary_dot_fc_accumulate_core #(
	parameter int ACC_WIDTH  = tdfa_pkg::ACC_WIDTH_DEF,
	parameter int FIFO_DEPTH = tdfa_pkg::FIFO_DEPTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	// act_0..act_7 [127:0], plus_bits [135:128], minus_bits [143:136], bias_value [159:144]
	input  wire logic [tdfa_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	input  wire logic                              s_axis_tlast,
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	// neuron_out [15:0]
	output logic [tdfa_pkg::OUT_W-1:0]             m_axis_tdata,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [tdfa_pkg::ALPHA_W-1:0]      cfg_data
);

	logic [tdfa_pkg::ALPHA_W-1:0]  alpha_q;
	logic                          fr_valid;
	logic                          fr_ready;
	tdfa_pkg::tdfa_entry_t         fr_entry;
	logic                          bk_valid;
	logic                          bk_ready;
	tdfa_pkg::tdfa_entry_t         bk_entry;
	tdfa_pkg::tdfa_fifo_status_t   fifo_st;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= tdfa_pkg::ALPHA_RESET;
		end else if (cfg_valid && cfg_ready) begin
			alpha_q <= cfg_data;
		end
	end

	tdfa_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_data   (s_axis_tdata),
		.in_last   (s_axis_tlast),
		.out_valid (fr_valid),
		.out_ready (fr_ready),
		.out_entry (fr_entry)
	);

	tdfa_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fr_valid),
		.push_ready (fr_ready),
		.push_entry (fr_entry),
		.pop_valid  (bk_valid),
		.pop_ready  (bk_ready),
		.pop_entry  (bk_entry),
		.status     (fifo_st)
	);

	tdfa_back #(
		.ACC_WIDTH (ACC_WIDTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.alpha_scale (alpha_q),
		.in_valid    (bk_valid),
		.in_ready    (bk_ready),
		.in_entry    (bk_entry),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_data    (m_axis_tdata)
	);

	a_fifo_flags: assert property (@(posedge clk) disable iff (!arst_n)
		!(fifo_st.full && fifo_st.empty))
		else $error("queue full and empty at once");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_st.empty |-> s_axis_tready)
		else $error("input stalled with an empty queue");

	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_st.push && !fifo_st.pop |=> !fifo_st.empty)
		else $error("queue empty after a push");

	a_push_flow: assert property (@(posedge clk) disable iff (!arst_n)
		fr_valid && !fifo_st.full |-> fifo_st.push)
		else $error("front request not pushed while queue has room");

endmodule

`default_nettype wire
